FILE: hw/rtl/bgs_pkg.sv
// Shared types, constants and helper functions for the biped gait servo sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bgs_pkg;

  // Field widths.
  localparam int ELAPSED_W = 16;
  localparam int CMD_W     = 2;
  localparam int ANGLE_W   = 10;
  localparam int TIME_W    = 21;
  localparam int POSE_W    = 11;
  localparam int SERVO_W   = 13;
  localparam int MAG_W     = 12;
  localparam int QUO_W     = 12;
  localparam int YAW_W     = 12;
  localparam int ROLL_W    = 11;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 21;

  // Legal move duration window, microseconds.
  localparam logic [TIME_W-1:0] DUR_MIN = 21'd65536;
  localparam logic [TIME_W-1:0] DUR_MAX = 21'd2000000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_ANGLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_PIVOT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_PIVOT_TURN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_FREE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_DUR        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_DUR       = 3'd6;

  // Configuration reset values.
  localparam logic [ANGLE_W-1:0] RST_TWIST_ANGLE     = 10'd300;
  localparam logic [ANGLE_W-1:0] RST_TURN_ANGLE      = 10'd150;
  localparam logic [ANGLE_W-1:0] RST_ROLL_PIVOT      = 10'd280;
  localparam logic [ANGLE_W-1:0] RST_ROLL_PIVOT_TURN = 10'd310;
  localparam logic [ANGLE_W-1:0] RST_ROLL_FREE       = 10'd700;
  localparam logic [TIME_W-1:0]  RST_ROLL_DUR        = 21'd200000;
  localparam logic [TIME_W-1:0]  RST_TWIST_DUR       = 21'd400000;

  typedef enum logic [PHASE_W-1:0] {
    PH_STILL = 3'd0,
    PH_R_END = 3'd1,
    PH_R1    = 3'd2,
    PH_R2    = 3'd3,
    PH_L1    = 3'd4,
    PH_L2    = 3'd5,
    PH_L_END = 3'd6
  } gait_phase_t;

  typedef enum logic [1:0] {
    PIV_CENTER = 2'd0,
    PIV_RIGHT  = 2'd1,
    PIV_LEFT   = 2'd2
  } pivot_t;

  typedef enum logic [1:0] {
    LANE_R_YAW  = 2'd0,
    LANE_R_ROLL = 2'd1,
    LANE_L_YAW  = 2'd2,
    LANE_L_ROLL = 2'd3
  } lane_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CMP,
    S_TT,
    S_LERP,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_LOAD,
    L_DIV,
    L_FIN
  } lerp_state_t;

  // Current pose state published by the gait machine.
  typedef struct packed {
    gait_phase_t              phase;
    pivot_t                   start_pivot;
    logic signed [POSE_W-1:0] start_twist;
    logic signed [POSE_W-1:0] start_toes;
    pivot_t                   target_pivot;
    logic signed [POSE_W-1:0] target_twist;
    logic signed [POSE_W-1:0] target_toes;
    logic                     use_twist_time;
  } gait_pose_t;

  // One interpolation job for the shared unit.
  typedef struct packed {
    logic signed [SERVO_W-1:0] s;
    logic signed [SERVO_W-1:0] e;
    logic [TIME_W-1:0]         tt;
    logic [TIME_W-1:0]         dur;
  } lerp_req_t;

  // Walk command decode: the pattern 2 saturates to -1.
  function automatic logic signed [CMD_W-1:0] cmd_value(input logic [CMD_W-1:0] raw);
    logic signed [CMD_W-1:0] v;
    case (raw)
      2'b00:   v = 2'sd0;
      2'b01:   v = 2'sd1;
      default: v = -2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic [TIME_W-1:0] clamp_dur(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (v < DUR_MIN) r = DUR_MIN;
    else if (v > DUR_MAX) r = DUR_MAX;
    else r = v;
    return r;
  endfunction

  // Servo offset of one lane for a given pose.
  function automatic logic signed [SERVO_W-1:0] pose_angle(
    input lane_t                    lane,
    input pivot_t                   pivot,
    input logic signed [POSE_W-1:0] twist,
    input logic signed [POSE_W-1:0] toes,
    input logic [ANGLE_W-1:0]       rp,
    input logic [ANGLE_W-1:0]       rpt,
    input logic [ANGLE_W-1:0]       rf
  );
    logic signed [SERVO_W-1:0] pr;
    logic signed [SERVO_W-1:0] fr;
    logic signed [SERVO_W-1:0] r;
    pr = (toes != '0) ? $signed({3'b000, rpt}) : $signed({3'b000, rp});
    fr = $signed({3'b000, rf});
    case (lane)
      LANE_R_YAW:  r = SERVO_W'(twist) + SERVO_W'(toes);
      LANE_L_YAW:  r = SERVO_W'(twist) - SERVO_W'(toes);
      LANE_R_ROLL: begin
        case (pivot)
          PIV_RIGHT: r = -pr;
          PIV_LEFT:  r = fr;
          default:   r = '0;
        endcase
      end
      LANE_L_ROLL: begin
        case (pivot)
          PIV_RIGHT: r = -fr;
          PIV_LEFT:  r = pr;
          default:   r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bgs_if.sv
// Handshake channel interfaces: tick input, servo result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface bgs_in_if import bgs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ELAPSED_W-1:0]    elapsed_us;
  logic signed [CMD_W-1:0] forward;
  logic signed [CMD_W-1:0] turn;

  modport source (output valid, elapsed_us, forward, turn, input ready);
  modport sink (input valid, elapsed_us, forward, turn, output ready);
endinterface

interface bgs_out_if import bgs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [YAW_W-1:0]  right_yaw;
  logic signed [ROLL_W-1:0] right_roll;
  logic signed [YAW_W-1:0]  left_yaw;
  logic signed [ROLL_W-1:0] left_roll;
  logic [PHASE_W-1:0]       phase_out;

  modport source (output valid, right_yaw, right_roll, left_yaw, left_roll, phase_out,
                  input ready);
  modport sink (input valid, right_yaw, right_roll, left_yaw, left_roll, phase_out,
                output ready);
endinterface

interface bgs_cfg_if import bgs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/biped_gait_servo_sequencer.sv
// Top level of the biped gait servo sequencer: tick sequencer, configuration and output stage.
// Each tick makes four passes (one per servo lane) through the shared multiply/divide
//   unit before its result is loaded into the output register.
// Input is not ready while a tick is in work, so a new tick is taken only after the
//   last result has been loaded. Configuration writes are taken every cycle.
// Reset (rst, synchronous): gait at stand still, pose centered, time cleared, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module biped_gait_servo_sequencer import bgs_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  bgs_in_if.sink     in_ch,
  bgs_out_if.source  out_ch,
  bgs_cfg_if.sink    cfg_ch
);

  // Configuration registers.
  logic [ANGLE_W-1:0] twist_angle;
  logic [ANGLE_W-1:0] turn_angle;
  logic [ANGLE_W-1:0] roll_pivot;
  logic [ANGLE_W-1:0] roll_pivot_turn;
  logic [ANGLE_W-1:0] roll_free;
  logic [TIME_W-1:0]  roll_duration_us;
  logic [TIME_W-1:0]  twist_duration_us;

  // Sequencer state and the captured tick.
  seq_state_t              state;
  seq_state_t              state_next;
  logic [ELAPSED_W-1:0]    el_reg;
  logic signed [CMD_W-1:0] f_reg;
  logic signed [CMD_W-1:0] t_reg;
  logic [TIME_W-1:0]       time_accum;
  logic [TIME_W:0]         accum_sum;
  logic [TIME_W-1:0]       dur_reg;
  logic [TIME_W-1:0]       tt_reg;
  logic [1:0]              lane;
  logic signed [SERVO_W-1:0] res [4];

  // Output register.
  logic                     out_valid;
  logic signed [YAW_W-1:0]  right_yaw;
  logic signed [ROLL_W-1:0] right_roll;
  logic signed [YAW_W-1:0]  left_yaw;
  logic signed [ROLL_W-1:0] left_roll;
  logic [PHASE_W-1:0]       phase_out;

  // Control.
  logic       in_take;
  logic       advance;
  logic       lerp_start;
  logic       out_load;
  logic       over_dur;
  logic [TIME_W-1:0] cur_dur;

  gait_pose_t                pose;
  lerp_req_t                 lerp_req;
  logic                      lerp_done;
  logic signed [SERVO_W-1:0] lerp_value;

  assign in_take = in_ch.valid && in_ch.ready;

  // The move duration always follows the pose currently loaded; after a phase
  // advance it already reflects the new move in the next state.
  assign cur_dur  = clamp_dur(pose.use_twist_time ? twist_duration_us : roll_duration_us);
  assign over_dur = (accum_sum > {1'b0, cur_dur});

  // Each lane interpolates from the start pose to the target pose.
  always_comb begin
    lerp_req.s   = pose_angle(lane_t'(lane), pose.start_pivot, pose.start_twist,
                              pose.start_toes, roll_pivot, roll_pivot_turn, roll_free);
    lerp_req.e   = pose_angle(lane_t'(lane), pose.target_pivot, pose.target_twist,
                              pose.target_toes, roll_pivot, roll_pivot_turn, roll_free);
    lerp_req.tt  = tt_reg;
    lerp_req.dur = dur_reg;
  end

  bgs_gait u_gait (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .f           (f_reg),
    .t           (t_reg),
    .twist_angle (twist_angle),
    .turn_angle  (turn_angle),
    .pose        (pose)
  );

  bgs_lerp_unit u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .req   (lerp_req),
    .done  (lerp_done),
    .value (lerp_value)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take) state_next = S_ADD;
      S_ADD:   state_next = S_CMP;
      S_CMP:   state_next = S_TT;
      S_TT:    state_next = S_LERP;
      S_LERP:  state_next = S_WAIT;
      S_WAIT: begin
        if (lerp_done) begin
          state_next = (lane == 2'd3) ? S_DONE : S_LERP;
        end
      end
      S_DONE:  if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = (state == S_IDLE);
    advance     = (state == S_CMP) && over_dur;
    lerp_start  = (state == S_LERP);
    out_load    = (state == S_DONE) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tick capture, time accumulation and lane bookkeeping. When the accumulated
  // time passes the current duration, one duration is removed and the gait
  // advances in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_accum <= '0;
    end else if (state == S_CMP) begin
      if (over_dur) begin
        time_accum <= TIME_W'(accum_sum - {1'b0, cur_dur});
      end else begin
        time_accum <= accum_sum[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      el_reg <= in_ch.elapsed_us;
      f_reg  <= cmd_value(in_ch.forward);
      t_reg  <= cmd_value(in_ch.turn);
    end
    if (state == S_ADD) begin
      accum_sum <= {1'b0, time_accum} + (TIME_W + 1)'(el_reg);
    end
    if (state == S_TT) begin
      // The interpolation ratio saturates at one.
      dur_reg <= cur_dur;
      tt_reg  <= (time_accum > cur_dur) ? cur_dur : time_accum;
      lane    <= 2'd0;
    end
    if (state == S_WAIT && lerp_done) begin
      res[lane] <= lerp_value;
      lane      <= lane + 1'b1;
    end
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      right_yaw  <= res[LANE_R_YAW][YAW_W-1:0];
      right_roll <= res[LANE_R_ROLL][ROLL_W-1:0];
      left_yaw   <= res[LANE_L_YAW][YAW_W-1:0];
      left_roll  <= res[LANE_L_ROLL][ROLL_W-1:0];
      phase_out  <= pose.phase;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.right_yaw  = right_yaw;
  assign out_ch.right_roll = right_roll;
  assign out_ch.left_yaw   = left_yaw;
  assign out_ch.left_roll  = left_roll;
  assign out_ch.phase_out  = phase_out;

  // Configuration port: always ready; writes beyond the register list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      twist_angle       <= RST_TWIST_ANGLE;
      turn_angle        <= RST_TURN_ANGLE;
      roll_pivot        <= RST_ROLL_PIVOT;
      roll_pivot_turn   <= RST_ROLL_PIVOT_TURN;
      roll_free         <= RST_ROLL_FREE;
      roll_duration_us  <= RST_ROLL_DUR;
      twist_duration_us <= RST_TWIST_DUR;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_TWIST_ANGLE:     twist_angle       <= cfg_ch.data[ANGLE_W-1:0];
        REG_TURN_ANGLE:      turn_angle        <= cfg_ch.data[ANGLE_W-1:0];
        REG_ROLL_PIVOT:      roll_pivot        <= cfg_ch.data[ANGLE_W-1:0];
        REG_ROLL_PIVOT_TURN: roll_pivot_turn   <= cfg_ch.data[ANGLE_W-1:0];
        REG_ROLL_FREE:       roll_free         <= cfg_ch.data[ANGLE_W-1:0];
        REG_ROLL_DUR:        roll_duration_us  <= cfg_ch.data[TIME_W-1:0];
        REG_TWIST_DUR:       twist_duration_us <= cfg_ch.data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The accumulator never holds more than the longest legal duration, since
  // each tick adds less than the shortest duration it can remove.
  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    time_accum <= DUR_MAX) else $error("time accumulator out of bound");
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_ADD) else $error("accepted tick did not start");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> out_valid) else $error("result not loaded");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bgs_lerp_unit.sv
// Shared interpolation unit: one multiply, then a restoring divide, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module bgs_lerp_unit import bgs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire lerp_req_t                 req,
  output logic                           done,
  output logic signed [SERVO_W-1:0]      value
);

  localparam int CNT_W  = $clog2(QUO_W);
  localparam int PROD_W = MAG_W + TIME_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DSH_W  = TIME_W + QUO_W;

  lerp_state_t state;
  lerp_state_t state_next;

  logic [CNT_W-1:0]          cnt;
  logic signed [SERVO_W-1:0] s_reg;
  logic                      neg_reg;
  logic [MAG_W-1:0]          mag_reg;
  logic [TIME_W-1:0]         tt_reg;
  logic [TIME_W-1:0]         dur_reg;
  logic [PROD_W-1:0]         prod;
  logic [NUM_W-1:0]          rem;
  logic [DSH_W-1:0]          dsh;
  logic [QUO_W-1:0]          quo;

  logic signed [SERVO_W-1:0] diff;
  logic signed [SERVO_W-1:0] diff_abs;
  logic                      ge;

  assign diff     = req.e - req.s;
  assign diff_abs = (diff < 0) ? -diff : diff;
  assign ge       = (rem >= {1'b0, dsh});

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE:  if (start) state_next = L_MUL;
      L_MUL:   state_next = L_LOAD;
      L_LOAD:  state_next = L_DIV;
      L_DIV:   if (cnt == CNT_W'(QUO_W - 1)) state_next = L_FIN;
      L_FIN:   state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == L_FIN);
    value = neg_reg ? (s_reg - $signed({1'b0, quo})) : (s_reg + $signed({1'b0, quo}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          s_reg   <= req.s;
          neg_reg <= (diff < 0);
          mag_reg <= diff_abs[MAG_W-1:0];
          tt_reg  <= req.tt;
          dur_reg <= req.dur;
        end
      end
      L_MUL: begin
        prod <= mag_reg * tt_reg;
      end
      L_LOAD: begin
        // Numerator 2*mag*t + dur over divisor 2*dur rounds half away from zero.
        rem <= {prod, 1'b0} + NUM_W'(dur_reg);
        dsh <= {dur_reg, 1'b0, {(QUO_W - 1){1'b0}}};
        quo <= '0;
        cnt <= '0;
      end
      L_DIV: begin
        if (ge) begin
          rem <= rem - {1'b0, dsh};
        end
        quo <= {quo[QUO_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == L_IDLE) else $error("lerp start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("lerp done longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bgs_gait.sv
// Seven-phase gait machine with first-stride command hold and target pose loading.
`timescale 1ns / 1ps
`default_nettype none

module bgs_gait import bgs_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic signed [CMD_W-1:0] f,
  input  wire logic signed [CMD_W-1:0] t,
  input  wire logic [ANGLE_W-1:0]      twist_angle,
  input  wire logic [ANGLE_W-1:0]      turn_angle,
  output gait_pose_t                   pose
);

  gait_pose_t              pose_next;
  gait_phase_t             phase_next;
  logic                    first_stride;
  logic                    first_stride_next;
  logic signed [CMD_W-1:0] held_forward;
  logic signed [CMD_W-1:0] held_turn;
  logic signed [CMD_W-1:0] held_forward_next;
  logic signed [CMD_W-1:0] held_turn_next;
  logic signed [CMD_W-1:0] f_eff;
  logic signed [CMD_W-1:0] t_eff;
  logic                    cmd_zero;
  logic signed [POSE_W-1:0] tw;
  logic signed [POSE_W-1:0] tn;

  // Phase decision and stride bookkeeping.
  always_comb begin
    held_forward_next = held_forward;
    held_turn_next    = held_turn;
    first_stride_next = first_stride;
    f_eff             = f;
    t_eff             = t;
    if (f != '0 || t != '0) begin
      held_forward_next = f;
      held_turn_next    = t;
    end else if (first_stride) begin
      f_eff = held_forward;
      t_eff = held_turn;
    end
    cmd_zero = (f_eff == '0) && (t_eff == '0);

    phase_next = pose.phase;
    if (cmd_zero) begin
      case (pose.phase)
        PH_R1, PH_R2: phase_next = PH_R_END;
        PH_L1, PH_L2: phase_next = PH_L_END;
        default:      phase_next = PH_STILL;
      endcase
    end else begin
      case (pose.phase)
        PH_R_END: phase_next = PH_R2;
        PH_R1:    phase_next = PH_R2;
        PH_R2: begin
          phase_next        = PH_L1;
          first_stride_next = 1'b0;
        end
        PH_L1:    phase_next = PH_L2;
        PH_L2: begin
          phase_next        = PH_R1;
          first_stride_next = 1'b0;
        end
        PH_L_END: phase_next = PH_L2;
        default: begin
          phase_next        = PH_R_END;
          first_stride_next = 1'b1;
        end
      endcase
    end
  end

  // Target pose for the new phase; the raw command sets twist and toes.
  always_comb begin
    case (f)
      2'sd1:   tw = $signed({1'b0, twist_angle});
      -2'sd1:  tw = -$signed({1'b0, twist_angle});
      default: tw = '0;
    endcase
    case (t)
      2'sd1:   tn = $signed({1'b0, turn_angle});
      -2'sd1:  tn = -$signed({1'b0, turn_angle});
      default: tn = '0;
    endcase

    pose_next.phase        = phase_next;
    pose_next.start_pivot  = pose.target_pivot;
    pose_next.start_twist  = pose.target_twist;
    pose_next.start_toes   = pose.target_toes;
    pose_next.target_twist = '0;
    pose_next.target_toes  = '0;
    case (phase_next)
      PH_R_END: pose_next.target_pivot = PIV_RIGHT;
      PH_L_END: pose_next.target_pivot = PIV_LEFT;
      PH_R1: begin
        pose_next.target_pivot = PIV_RIGHT;
        pose_next.target_twist = tw;
        pose_next.target_toes  = tn;
      end
      PH_R2: begin
        pose_next.target_pivot = PIV_RIGHT;
        pose_next.target_twist = -tw;
        pose_next.target_toes  = -tn;
      end
      PH_L1: begin
        pose_next.target_pivot = PIV_LEFT;
        pose_next.target_twist = -tw;
        pose_next.target_toes  = -tn;
      end
      PH_L2: begin
        pose_next.target_pivot = PIV_LEFT;
        pose_next.target_twist = tw;
        pose_next.target_toes  = tn;
      end
      default: pose_next.target_pivot = PIV_CENTER;
    endcase
    pose_next.use_twist_time = (pose.target_pivot == pose_next.target_pivot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose.phase          <= PH_STILL;
      pose.start_pivot    <= PIV_CENTER;
      pose.start_twist    <= '0;
      pose.start_toes     <= '0;
      pose.target_pivot   <= PIV_CENTER;
      pose.target_twist   <= '0;
      pose.target_toes    <= '0;
      pose.use_twist_time <= 1'b0;
      first_stride        <= 1'b1;
      held_forward        <= '0;
      held_turn           <= '0;
    end else if (advance) begin
      pose         <= pose_next;
      first_stride <= first_stride_next;
      held_forward <= held_forward_next;
      held_turn    <= held_turn_next;
    end
  end

`ifndef SYNTHESIS
  a_right_pivot: assert property (@(posedge clk) disable iff (rst)
    (pose.phase == PH_R_END || pose.phase == PH_R1 || pose.phase == PH_R2)
      |-> pose.target_pivot == PIV_RIGHT) else $error("right phase without right pivot");
`endif

endmodule

`default_nettype wire

FILE: sim/bgs_servo_checker.sv
// Checker for the biped gait servo sequencer: predicts each servo frame and compares it.
`timescale 1ns / 1ps

module bgs_servo_checker import bgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  bgs_in_if    in_ch,
  bgs_out_if   out_ch,
  bgs_cfg_if   cfg_ch,
  output int   mismatches,
  output int   frames_due
);

  typedef struct packed {
    logic signed [YAW_W-1:0]  right_yaw;
    logic signed [ROLL_W-1:0] right_roll;
    logic signed [YAW_W-1:0]  left_yaw;
    logic signed [ROLL_W-1:0] left_roll;
    logic [PHASE_W-1:0]       phase;
  } servo_frame_t;

  servo_frame_t servo_frames_due[$];

  // Register copies: angles at their field width, durations at full written width.
  int unsigned twist_gain, turn_gain, stance_roll, stance_roll_turn, free_roll;
  int unsigned roll_time_reg, twist_time_reg;

  // Gait and pose state.
  gait_phase_t gait_state;
  bit          opening_stride;
  int          last_fwd, last_turn;
  pivot_t      from_pivot, to_pivot;
  int          from_twist, from_toes, to_twist, to_toes;
  bit          twist_timed;
  int unsigned elapsed_sum;

  function automatic int walk_cmd(input logic [CMD_W-1:0] raw);
    if (raw == 2'b00) return 0;
    return raw[1] ? -1 : 1;
  endfunction

  // Duration of the current move, held inside the legal window.
  function automatic int unsigned move_time();
    int unsigned d;
    d = twist_timed ? twist_time_reg : roll_time_reg;
    if (d < DUR_MIN) d = DUR_MIN;
    else if (d > DUR_MAX) d = DUR_MAX;
    return d;
  endfunction

  function automatic void advance_gait(input int f, input int t);
    if (f != 0 || t != 0) begin
      last_fwd = f;
      last_turn = t;
    end else if (opening_stride) begin
      // A stop during the first stride keeps walking on the last real command.
      f = last_fwd;
      t = last_turn;
    end
    if (f == 0 && t == 0) begin
      case (gait_state)
        PH_R1, PH_R2: gait_state = PH_R_END;
        PH_L1, PH_L2: gait_state = PH_L_END;
        default:      gait_state = PH_STILL;
      endcase
    end else begin
      case (gait_state)
        PH_R_END, PH_R1: gait_state = PH_R2;
        PH_R2: begin
          gait_state = PH_L1;
          opening_stride = 1'b0;
        end
        PH_L1, PH_L_END: gait_state = PH_L2;
        PH_L2: begin
          gait_state = PH_R1;
          opening_stride = 1'b0;
        end
        default: begin
          gait_state = PH_R_END;
          opening_stride = 1'b1;
        end
      endcase
    end
  endfunction

  function automatic void load_pose(input int f, input int t);
    int tw, tn;
    tw = int'(twist_gain) * f;
    tn = int'(turn_gain) * t;
    from_pivot = to_pivot;
    from_twist = to_twist;
    from_toes = to_toes;
    to_twist = 0;
    to_toes = 0;
    case (gait_state)
      PH_R_END: to_pivot = PIV_RIGHT;
      PH_L_END: to_pivot = PIV_LEFT;
      PH_R1: begin
        to_pivot = PIV_RIGHT;
        to_twist = tw;
        to_toes = tn;
      end
      PH_R2: begin
        to_pivot = PIV_RIGHT;
        to_twist = -tw;
        to_toes = -tn;
      end
      PH_L1: begin
        to_pivot = PIV_LEFT;
        to_twist = -tw;
        to_toes = -tn;
      end
      PH_L2: begin
        to_pivot = PIV_LEFT;
        to_twist = tw;
        to_toes = tn;
      end
      default: to_pivot = PIV_CENTER;
    endcase
    twist_timed = (from_pivot == to_pivot);
  endfunction

  function automatic int servo_offset(input lane_t lane, input pivot_t p,
                                      input int tw, input int toes);
    int pr, fr, v;
    pr = (toes != 0) ? int'(stance_roll_turn) : int'(stance_roll);
    fr = int'(free_roll);
    case (lane)
      LANE_R_YAW:  v = tw + toes;
      LANE_L_YAW:  v = tw - toes;
      LANE_R_ROLL: v = (p == PIV_RIGHT) ? -pr : (p == PIV_LEFT) ? fr : 0;
      default:     v = (p == PIV_RIGHT) ? -fr : (p == PIV_LEFT) ? pr : 0;
    endcase
    return v;
  endfunction

  // Linear blend from start to target pose, rounded half away from zero.
  function automatic int lane_ease(input lane_t lane, input longint unsigned t,
                                   input longint unsigned dur);
    int s, e;
    longint d;
    longint unsigned absd, q;
    s = servo_offset(lane, from_pivot, from_twist, from_toes);
    e = servo_offset(lane, to_pivot, to_twist, to_toes);
    d = longint'(e) - longint'(s);
    absd = (d < 0) ? -d : d;
    q = (2 * absd * t + dur) / (2 * dur);
    return (d < 0) ? s - int'(q) : s + int'(q);
  endfunction

  function automatic servo_frame_t predict_servo_frame(input logic [ELAPSED_W-1:0] el,
                                                       input logic [CMD_W-1:0] fw,
                                                       input logic [CMD_W-1:0] tn);
    servo_frame_t fr;
    int f, t, v;
    int unsigned dur, tt;
    f = walk_cmd(fw);
    t = walk_cmd(tn);
    elapsed_sum += el;
    dur = move_time();
    if (elapsed_sum > dur) begin
      elapsed_sum -= dur;
      advance_gait(f, t);
      load_pose(f, t);
      dur = move_time();
    end
    // After a duration is lowered the sum may still exceed it; the blend stops at the target.
    tt = (elapsed_sum > dur) ? dur : elapsed_sum;
    v = lane_ease(LANE_R_YAW, tt, dur);
    fr.right_yaw = v[YAW_W-1:0];
    v = lane_ease(LANE_R_ROLL, tt, dur);
    fr.right_roll = v[ROLL_W-1:0];
    v = lane_ease(LANE_L_YAW, tt, dur);
    fr.left_yaw = v[YAW_W-1:0];
    v = lane_ease(LANE_L_ROLL, tt, dur);
    fr.left_roll = v[ROLL_W-1:0];
    fr.phase = gait_state;
    return fr;
  endfunction

  function automatic int field_bad(input string what, input logic signed [31:0] want,
                                   input logic signed [31:0] got);
    if (want !== got) begin
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    servo_frame_t want;
    int bad;
    if (rst) begin
      twist_gain = RST_TWIST_ANGLE;
      turn_gain = RST_TURN_ANGLE;
      stance_roll = RST_ROLL_PIVOT;
      stance_roll_turn = RST_ROLL_PIVOT_TURN;
      free_roll = RST_ROLL_FREE;
      roll_time_reg = RST_ROLL_DUR;
      twist_time_reg = RST_TWIST_DUR;
      gait_state = PH_STILL;
      opening_stride = 1'b1;
      last_fwd = 0;
      last_turn = 0;
      from_pivot = PIV_CENTER;
      to_pivot = PIV_CENTER;
      from_twist = 0;
      from_toes = 0;
      to_twist = 0;
      to_toes = 0;
      twist_timed = 1'b0;
      elapsed_sum = 0;
      servo_frames_due.delete();
      mismatches <= 0;
      frames_due <= 0;
    end else begin
      bad = 0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TWIST_ANGLE:     twist_gain = cfg_ch.data[ANGLE_W-1:0];
          REG_TURN_ANGLE:      turn_gain = cfg_ch.data[ANGLE_W-1:0];
          REG_ROLL_PIVOT:      stance_roll = cfg_ch.data[ANGLE_W-1:0];
          REG_ROLL_PIVOT_TURN: stance_roll_turn = cfg_ch.data[ANGLE_W-1:0];
          REG_ROLL_FREE:       free_roll = cfg_ch.data[ANGLE_W-1:0];
          REG_ROLL_DUR:        roll_time_reg = cfg_ch.data;
          REG_TWIST_DUR:       twist_time_reg = cfg_ch.data;
          default:             ;
        endcase
      end
      // Compare before predicting so a frame never meets its own expectation early.
      if (out_ch.valid && out_ch.ready) begin
        if (servo_frames_due.size() == 0) begin
          $display("time %0t: servo frame with none expected, phase %0d", $time,
                   out_ch.phase_out);
          bad = 1;
        end else begin
          want = servo_frames_due.pop_front();
          bad = field_bad("right_yaw", want.right_yaw, out_ch.right_yaw)
              + field_bad("right_roll", want.right_roll, out_ch.right_roll)
              + field_bad("left_yaw", want.left_yaw, out_ch.left_yaw)
              + field_bad("left_roll", want.left_roll, out_ch.left_roll)
              + field_bad("phase_out", $signed({1'b0, want.phase}),
                          $signed({1'b0, out_ch.phase_out}));
        end
      end
      if (in_ch.valid && in_ch.ready)
        servo_frames_due.push_back(predict_servo_frame(in_ch.elapsed_us, in_ch.forward,
                                                       in_ch.turn));
      mismatches <= mismatches + bad;
      frames_due <= servo_frames_due.size();
    end
  end

endmodule

FILE: sim/tb_biped_gait_servo_sequencer.sv
// Testbench top for the biped gait servo sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_biped_gait_servo_sequencer;
  import bgs_pkg::*;

  localparam int     CLK_HALF_NS  = 2;
  localparam int     RESET_CYCLES = 12;
  // A little beyond the tick latency, so a stray extra frame would still show up.
  localparam int     DRAIN_CYCLES = 80;
  // Slowest honest run is roughly 1000 ticks, each with the longest idle gap, busy time
  // and output stall; this limit leaves several times that.
  localparam longint CYCLE_LIMIT  = 2000000;

  // Register index beyond the defined set; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Raw walk command patterns. The pattern 2'b10 is the saturating case of -2.
  localparam logic [CMD_W-1:0] CMD_ZERO  = 2'b00;
  localparam logic [CMD_W-1:0] CMD_PLUS  = 2'b01;
  localparam logic [CMD_W-1:0] CMD_MINUS = 2'b11;
  localparam logic [CMD_W-1:0] CMD_SAT   = 2'b10;

  localparam logic [ELAPSED_W-1:0] EL_MAX = 16'hFFFF;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  bit     calm = 1'b0;      // when set, neither side idles or stalls
  int     stall_left = 0;
  int     mismatches;
  int     frames_due;
  longint cycles = 0;

  bgs_in_if  in_ch ();
  bgs_out_if out_ch ();
  bgs_cfg_if cfg_ch ();

  biped_gait_servo_sequencer dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  bgs_servo_checker frame_check (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .mismatches(mismatches),
    .frames_due(frames_due)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_biped_gait_servo_sequencer NOT OK");
      $finish;
    end
  end

  // Result side backpressure. Ready drops in about a third of the cycles, and now and
  // then for a long stretch, so stalls land on every step of the block's work.
  always @(negedge clk) begin
    if (rst || calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 999) < 2) begin
      stall_left = $urandom_range(10, 90);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // Offers one tick and returns at the edge where the transaction is taken. Valid is
  // left high so back-to-back ticks need a single assignment per falling edge.
  task automatic send_tick(input logic [ELAPSED_W-1:0] el, input logic [CMD_W-1:0] fw,
                           input logic [CMD_W-1:0] tn);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 4) gap = $urandom_range(1, 90);
    while (!calm && (gap > 0 || $urandom_range(0, 99) < 36)) begin
      in_ch.valid <= 1'b0;
      if (gap > 0) gap--;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.elapsed_us <= el;
    in_ch.forward <= fw;
    in_ch.turn <= tn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering ticks and waits until every predicted frame has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frames_due != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val[CFG_DAT_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Rewrites every register, only once the block has gone quiet.
  task automatic program_regs(input int unsigned tw, input int unsigned tn,
                              input int unsigned rp, input int unsigned rpt,
                              input int unsigned rf, input int unsigned rd,
                              input int unsigned td);
    wait_drained();
    put_reg(REG_TWIST_ANGLE, tw);
    put_reg(REG_TURN_ANGLE, tn);
    put_reg(REG_ROLL_PIVOT, rp);
    put_reg(REG_ROLL_PIVOT_TURN, rpt);
    put_reg(REG_ROLL_FREE, rf);
    put_reg(REG_ROLL_DUR, rd);
    put_reg(REG_TWIST_DUR, td);
    put_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_random(input int unsigned rd, input int unsigned td);
    program_regs($urandom_range(0, 1000), $urandom_range(0, 1000), $urandom_range(0, 1000),
                 $urandom_range(0, 1000), $urandom_range(0, 1000), rd, td);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CMD_SAT;
    if (r <= 3) return CMD_ZERO;
    if (r <= 6) return CMD_PLUS;
    return CMD_MINUS;
  endfunction

  // Random walking. Most of the time a command is held for a run of ticks, as a real
  // operator would, so the gait gets through full strides; stops and per-tick noise
  // make up the rest.
  task automatic walk(input int count);
    logic [CMD_W-1:0] hold_f, hold_t, fw, tn;
    logic [ELAPSED_W-1:0] el;
    int run_left, r;
    bit noise;
    run_left = 0;
    noise = 1'b0;
    hold_f = CMD_ZERO;
    hold_t = CMD_ZERO;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        noise = 1'b0;
        if (r < 70) begin
          do begin
            hold_f = pick_cmd();
            hold_t = pick_cmd();
          end while (hold_f == CMD_ZERO && hold_t == CMD_ZERO);
          run_left = $urandom_range(5, 40);
        end else if (r < 85) begin
          hold_f = CMD_ZERO;
          hold_t = CMD_ZERO;
          run_left = $urandom_range(2, 15);
        end else begin
          noise = 1'b1;
          run_left = $urandom_range(1, 8);
        end
      end
      run_left--;
      fw = noise ? pick_cmd() : hold_f;
      tn = noise ? pick_cmd() : hold_t;
      r = $urandom_range(0, 99);
      if (r < 5) el = '0;
      else if (r < 10) el = EL_MAX;
      else if (r < 20) el = ELAPSED_W'($urandom_range(0, 2000));
      else el = ELAPSED_W'($urandom_range(0, 65535));
      send_tick(el, fw, tn);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.elapsed_us = '0;
    in_ch.forward = '0;
    in_ch.turn = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset settings (roll move 200000 us, twist move 400000 us).
    // A zero tick at stand still, then full-scale ticks start the first stride.
    send_tick('0, CMD_ZERO, CMD_ZERO);
    repeat (4) send_tick(EL_MAX, CMD_PLUS, CMD_ZERO);
    // Stop commands during the first stride: the phase keeps walking on the held
    // command while the loaded pose follows the zero command.
    repeat (3) send_tick(EL_MAX, CMD_ZERO, CMD_ZERO);
    // Backward and turning; the stride completes and the first-stride hold ends.
    repeat (6) send_tick(EL_MAX, CMD_MINUS, CMD_PLUS);
    // The -2 pattern on each command, which must act as -1.
    repeat (3) send_tick(EL_MAX, CMD_SAT, CMD_MINUS);
    send_tick('0, CMD_ZERO, CMD_SAT);
    send_tick(EL_MAX, CMD_ZERO, CMD_SAT);
    send_tick(EL_MAX, CMD_PLUS, CMD_MINUS);
    // Standing down toward an end phase.
    repeat (2) send_tick(EL_MAX, CMD_ZERO, CMD_ZERO);
    send_tick(16'd1, CMD_ZERO, CMD_ZERO);

    // Short moves under random gains, so the gait cycles many times.
    program_random($urandom_range(65536, 150000), $urandom_range(65536, 250000));
    walk(170);

    // Every gain and roll at zero, both durations at the bottom of the window.
    program_regs(0, 0, 0, 0, 0, DUR_MIN, DUR_MIN);
    walk(170);

    // Every gain and roll at its top, both durations at the top of the window.
    program_regs(1000, 1000, 1000, 1000, 1000, DUR_MAX, DUR_MAX);
    walk(130);

    // Both durations written below the window, so they clamp to the minimum. The time
    // left over from the slow moves above now exceeds the move length: the blend pins
    // at the target and one duration is taken off per tick.
    program_random(1000, 30000);
    walk(170);

    // A stretch with no idling on either side; the twist duration is written above the
    // window and must clamp to the maximum.
    calm = 1'b1;
    program_random($urandom_range(65536, 200000), 21'h1FFFFF);
    walk(170);
    calm = 1'b0;

    // Random settings again; halfway through the sender holds off until every frame
    // has been returned, then resumes from an empty pipeline.
    program_random($urandom_range(65536, 2000000), $urandom_range(65536, 400000));
    walk(90);
    wait_drained();
    walk(90);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && frames_due == 0) begin
      $display("tb_biped_gait_servo_sequencer OK");
    end else begin
      $display("tb_biped_gait_servo_sequencer NOT OK");
    end
    $finish;
  end

endmodule
